[rtl/core/dependency_counting_job_scheduler_top_macros.svh]
// Assertion macros shared by the job scheduler modules.
`ifndef DEPENDENCY_COUNTING_JOB_SCHEDULER_TOP_MACROS_SVH
`define DEPENDENCY_COUNTING_JOB_SCHEDULER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCJS_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCJS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/dcjs_pkg.sv]
// Types and constants shared by the job scheduler modules.
package dcjs_pkg;

    // Operation codes of a request.
    localparam logic [1:0] OP_SUBMIT   = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;

    // Status codes of a result.
    localparam logic [2:0] STAT_OK            = 3'd0;
    localparam logic [2:0] STAT_NOT_ACCEPTING = 3'd1;
    localparam logic [2:0] STAT_TABLE_FULL    = 3'd2;
    localparam logic [2:0] STAT_NOTHING_READY = 3'd3;
    localparam logic [2:0] STAT_SLOT_INACTIVE = 3'd4;

    // Fixed field widths.
    localparam int SLOT_W  = 5;
    localparam int DEPS_W  = 32;
    localparam int COUNT_W = 6;

    typedef struct packed {
        logic [1:0]        operation;
        logic              job_priority;
        logic [DEPS_W-1:0] dependency_mask;
        logic [SLOT_W-1:0] job_slot;
    } job_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [SLOT_W-1:0]  result_slot;
        logic               result_priority;
        logic [COUNT_W-1:0] jobs_outstanding;
        logic               all_done;
    } job_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic release_step;
        logic respond;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_dispatch;
        logic op_complete;
        logic release_pending;
    } dp_stat_t;

endpackage

[rtl/core/dcjs_datapath.sv]
// Job table, ready FIFOs and result register of the job scheduler.
`include "dependency_counting_job_scheduler_top_macros.svh"

module dcjs_datapath #(
    parameter int MAX_JOBS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_data,
    input  dcjs_pkg::job_req_t job,
    input  dcjs_pkg::dp_cmd_t  cmd,
    output dcjs_pkg::dp_stat_t st,
    output dcjs_pkg::job_rsp_t result
);

    localparam int SW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    // Lowest set bit of a slot vector.
    function automatic logic [SW:0] lowest_set(input logic [MAX_JOBS-1:0] vec);
        logic [SW:0] res;
        res = '0;
        for (int k = MAX_JOBS - 1; k >= 0; k--)
        begin
            if (vec[k])
            begin
                res = {1'b1, SW'(k)};
            end
        end
        return res;
    endfunction

    // Write address of a ring buffer: head plus count, wrapped.
    function automatic logic [SW-1:0] tail_addr(input logic [SW-1:0] head,
                                                input logic [CW-1:0] count);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(count);
        if (sum >= (CW+1)'(MAX_JOBS))
        begin
            sum = sum - (CW+1)'(MAX_JOBS);
        end
        return SW'(sum);
    endfunction

    // Head advance with wrap.
    function automatic logic [SW-1:0] head_inc(input logic [SW-1:0] head);
        return (head == SW'(MAX_JOBS - 1)) ? '0 : head + 1'b1;
    endfunction

    // Control state.
    logic                accepting_reg, accepting_next;
    logic [MAX_JOBS-1:0] active_reg, active_next;
    logic [MAX_JOBS-1:0] high_reg, high_next;
    logic [MAX_JOBS-1:0] wait_reg [MAX_JOBS];
    logic [MAX_JOBS-1:0] wait_next [MAX_JOBS];
    logic [MAX_JOBS-1:0] released_reg, released_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SW-1:0]       hi_head_reg, hi_head_next;
    logic [CW-1:0]       hi_cnt_reg, hi_cnt_next;
    logic [SW-1:0]       nm_head_reg, nm_head_next;
    logic [CW-1:0]       nm_cnt_reg, nm_cnt_next;

    // Payload state.
    dcjs_pkg::job_req_t  req_reg, req_next;
    dcjs_pkg::job_rsp_t  rsp_reg, rsp_next;
    logic [2:0]          res_status_reg, res_status_next;
    logic [SW-1:0]       res_slot_reg, res_slot_next;
    logic                res_prio_reg, res_prio_next;
    logic                res_done_reg, res_done_next;
    logic                use_fifo_reg, use_fifo_next;

    // Ready FIFO storage.
    logic [SW-1:0]       hi_mem [MAX_JOBS];
    logic [SW-1:0]       nm_mem [MAX_JOBS];
    logic [SW-1:0]       hi_rd_reg;
    logic [SW-1:0]       nm_rd_reg;

    // Helper signals.
    logic [MAX_JOBS-1:0] deps_ext;
    logic [MAX_JOBS-1:0] live;
    logic [MAX_JOBS-1:0] done_bit;
    logic [MAX_JOBS-1:0] release_vec;
    logic [SW-1:0]       j_idx;
    logic                slot_ok;
    logic [SW:0]         free_find;
    logic [SW:0]         rel_find;
    logic                push_en;
    logic                push_hi;
    logic [SW-1:0]       push_slot;
    logic                hi_we;
    logic                nm_we;
    logic                pop_hi;
    logic                pop_nm;

    // Dependency and completion terms of the captured request.
    always_comb
    begin
        deps_ext  = MAX_JOBS'(req_reg.dependency_mask);
        live      = active_reg & deps_ext;
        j_idx     = SW'(req_reg.job_slot);
        slot_ok   = (32'(req_reg.job_slot) < MAX_JOBS) && active_reg[j_idx];
        done_bit  = MAX_JOBS'(1) << j_idx;
        free_find = lowest_set(~active_reg);
        rel_find  = lowest_set(released_reg);
        for (int k = 0; k < MAX_JOBS; k++)
        begin
            release_vec[k] = active_reg[k] && (SW'(k) != j_idx) && wait_reg[k][j_idx]
                             && ((wait_reg[k] & ~done_bit) == '0);
        end
    end

    // Next-state logic of the table, FIFO pointers and results.
    always_comb
    begin
        accepting_next  = cfg_write ? cfg_data : accepting_reg;
        active_next     = active_reg;
        high_next       = high_reg;
        wait_next       = wait_reg;
        released_next   = released_reg;
        cnt_next        = cnt_reg;
        hi_head_next    = hi_head_reg;
        hi_cnt_next     = hi_cnt_reg;
        nm_head_next    = nm_head_reg;
        nm_cnt_next     = nm_cnt_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_prio_next   = res_prio_reg;
        res_done_next   = res_done_reg;
        use_fifo_next   = use_fifo_reg;
        push_en         = 1'b0;
        push_hi         = 1'b0;
        push_slot       = '0;
        pop_hi          = 1'b0;
        pop_nm          = 1'b0;
        hi_we           = 1'b0;
        nm_we           = 1'b0;

        if (cmd.capture)
        begin
            req_next = job;
        end

        // Execute the captured request.
        if (cmd.execute)
        begin
            res_status_next = dcjs_pkg::STAT_OK;
            res_slot_next   = '0;
            res_prio_next   = 1'b0;
            res_done_next   = 1'b0;
            use_fifo_next   = 1'b0;
            released_next   = '0;
            unique case (req_reg.operation)
                dcjs_pkg::OP_SUBMIT:
                begin
                    priority if (!accepting_reg)
                    begin
                        res_status_next = dcjs_pkg::STAT_NOT_ACCEPTING;
                    end
                    else if (!free_find[SW])
                    begin
                        res_status_next = dcjs_pkg::STAT_TABLE_FULL;
                    end
                    else
                    begin
                        active_next[free_find[SW-1:0]] = 1'b1;
                        high_next[free_find[SW-1:0]]   = req_reg.job_priority;
                        wait_next[free_find[SW-1:0]]   = live;
                        cnt_next                       = cnt_reg + 1'b1;
                        res_slot_next                  = free_find[SW-1:0];
                        if (live == '0)
                        begin
                            push_en   = 1'b1;
                            push_hi   = req_reg.job_priority;
                            push_slot = free_find[SW-1:0];
                        end
                    end
                end
                dcjs_pkg::OP_DISPATCH:
                begin
                    priority if (hi_cnt_reg != '0)
                    begin
                        pop_hi        = 1'b1;
                        res_prio_next = 1'b1;
                        use_fifo_next = 1'b1;
                    end
                    else if (nm_cnt_reg != '0)
                    begin
                        pop_nm        = 1'b1;
                        use_fifo_next = 1'b1;
                    end
                    else
                    begin
                        res_status_next = dcjs_pkg::STAT_NOTHING_READY;
                    end
                end
                dcjs_pkg::OP_COMPLETE:
                begin
                    if (!slot_ok)
                    begin
                        res_status_next = dcjs_pkg::STAT_SLOT_INACTIVE;
                    end
                    else
                    begin
                        for (int k = 0; k < MAX_JOBS; k++)
                        begin
                            wait_next[k] = wait_reg[k] & ~done_bit;
                        end
                        wait_next[j_idx]   = '0;
                        active_next[j_idx] = 1'b0;
                        released_next      = release_vec;
                        if (cnt_reg != '0)
                        begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                        res_done_next = (cnt_reg <= CW'(1));
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Move one released waiter, lowest slot first, into its FIFO.
        if (cmd.release_step && rel_find[SW])
        begin
            push_en                         = 1'b1;
            push_hi                         = high_reg[rel_find[SW-1:0]];
            push_slot                       = rel_find[SW-1:0];
            released_next[rel_find[SW-1:0]] = 1'b0;
        end

        // FIFO pointer updates; a push into a full FIFO is dropped.
        if (push_en && push_hi && (hi_cnt_reg < CW'(MAX_JOBS)))
        begin
            hi_we       = 1'b1;
            hi_cnt_next = hi_cnt_reg + 1'b1;
        end
        if (push_en && !push_hi && (nm_cnt_reg < CW'(MAX_JOBS)))
        begin
            nm_we       = 1'b1;
            nm_cnt_next = nm_cnt_reg + 1'b1;
        end
        if (pop_hi)
        begin
            hi_head_next = head_inc(hi_head_reg);
            hi_cnt_next  = hi_cnt_reg - 1'b1;
        end
        if (pop_nm)
        begin
            nm_head_next = head_inc(nm_head_reg);
            nm_cnt_next  = nm_cnt_reg - 1'b1;
        end

        // Load the outgoing result.
        if (cmd.respond)
        begin
            rsp_next.status           = res_status_reg;
            rsp_next.result_slot      = dcjs_pkg::SLOT_W'(use_fifo_reg
                                        ? (res_prio_reg ? hi_rd_reg : nm_rd_reg)
                                        : res_slot_reg);
            rsp_next.result_priority  = res_prio_reg;
            rsp_next.jobs_outstanding = dcjs_pkg::COUNT_W'(cnt_reg);
            rsp_next.all_done         = res_done_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepting_reg <= 1'b1;
            active_reg    <= '0;
            high_reg      <= '0;
            for (int k = 0; k < MAX_JOBS; k++)
            begin
                wait_reg[k] <= '0;
            end
            released_reg  <= '0;
            cnt_reg       <= '0;
            hi_head_reg   <= '0;
            hi_cnt_reg    <= '0;
            nm_head_reg   <= '0;
            nm_cnt_reg    <= '0;
        end
        else
        begin
            accepting_reg <= accepting_next;
            active_reg    <= active_next;
            high_reg      <= high_next;
            wait_reg      <= wait_next;
            released_reg  <= released_next;
            cnt_reg       <= cnt_next;
            hi_head_reg   <= hi_head_next;
            hi_cnt_reg    <= hi_cnt_next;
            nm_head_reg   <= nm_head_next;
            nm_cnt_reg    <= nm_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        rsp_reg        <= rsp_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_prio_reg   <= res_prio_next;
        res_done_reg   <= res_done_next;
        use_fifo_reg   <= use_fifo_next;
    end

    // High priority FIFO memory with registered read.
    always_ff @(posedge clk)
    begin
        if (hi_we)
        begin
            hi_mem[tail_addr(hi_head_reg, hi_cnt_reg)] <= push_slot;
        end
        if (pop_hi)
        begin
            hi_rd_reg <= hi_mem[hi_head_reg];
        end
    end

    // Normal priority FIFO memory with registered read.
    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            nm_mem[tail_addr(nm_head_reg, nm_cnt_reg)] <= push_slot;
        end
        if (pop_nm)
        begin
            nm_rd_reg <= nm_mem[nm_head_reg];
        end
    end

    // Status toward the controller.
    assign st.op_dispatch     = (req_reg.operation == dcjs_pkg::OP_DISPATCH);
    assign st.op_complete     = (req_reg.operation == dcjs_pkg::OP_COMPLETE);
    assign st.release_pending = |released_reg;
    assign result             = rsp_reg;

    // The outstanding count always matches the active slots.
    `DCJS_ASSERT_SAME(a_count_matches_table, clk, rst_n, 1'b1,
        cnt_reg == CW'($countones(active_reg)), "outstanding count disagrees with table")
    // Neither FIFO ever holds more entries than it has.
    `DCJS_ASSERT_SAME(a_fifo_bounded, clk, rst_n, 1'b1,
        (hi_cnt_reg <= CW'(MAX_JOBS)) && (nm_cnt_reg <= CW'(MAX_JOBS)), "ready FIFO overflow")
    // A successful completion frees its slot.
    `DCJS_ASSERT_NEXT(a_complete_frees, clk, rst_n,
        cmd.execute && (req_reg.operation == dcjs_pkg::OP_COMPLETE) && slot_ok,
        active_reg[$past(j_idx)] == 1'b0, "completed slot still active")

endmodule

[rtl/core/dcjs_controller.sv]
// Sequencing state machine and result handshake of the job scheduler.
`include "dependency_counting_job_scheduler_top_macros.svh"

module dcjs_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_stall,
    output logic               result_valid,
    input  logic               result_stall,
    input  dcjs_pkg::dp_stat_t st,
    output dcjs_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_EXEC    = 5'b00010,
        ST_POP     = 5'b00100,
        ST_RELEASE = 5'b01000,
        ST_RESPOND = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    // The result register can take a new result this cycle.
    assign out_free = !out_valid_reg || !result_stall;

    // Commands to the datapath.
    assign cmd.capture      = (state_reg == ST_IDLE) && job_valid;
    assign cmd.execute      = (state_reg == ST_EXEC);
    assign cmd.release_step = (state_reg == ST_RELEASE);
    assign cmd.respond      = (state_reg == ST_RESPOND) && out_free;

    assign job_stall    = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

    // State transitions.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (st.op_dispatch)
                begin
                    state_next = ST_POP;
                end
                else if (st.op_complete)
                begin
                    state_next = ST_RELEASE;
                end
                else
                begin
                    state_next = ST_RESPOND;
                end
            end
            ST_POP:
            begin
                state_next = ST_RESPOND;
            end
            ST_RELEASE:
            begin
                if (!st.release_pending)
                begin
                    state_next = ST_RESPOND;
                end
            end
            ST_RESPOND:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.respond)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted request is executed in the next cycle.
    `DCJS_ASSERT_NEXT(a_accept_executes, clk, rst_n, job_valid && !job_stall,
        state_reg == ST_EXEC, "accepted request not executed")
    // The release walk ends once no waiter is left.
    `DCJS_ASSERT_NEXT(a_release_ends, clk, rst_n,
        (state_reg == ST_RELEASE) && !st.release_pending,
        state_reg == ST_RESPOND, "release walk did not end")
    // A new result appears only out of the respond state.
    `DCJS_ASSERT_SAME(a_result_from_respond, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == ST_RESPOND), "result raised outside respond state")

endmodule

[rtl/core/dependency_counting_job_scheduler_top.sv]
// Top level of the dependency counting job scheduler.
//
// Usage: a request on the job channel (job_valid, job_stall, job) submits,
// dispatches or completes a job; each request yields exactly one result on
// the result channel (result_valid, result_stall, result). The write enable
// cfg_write with cfg_data sets the accepting-jobs flag; the user is to write it
// only while idle, which the block itself does not enforce. A request is taken when
// job_valid is high and job_stall is low; one request is in work at a time, so
// job_stall is high until its result is loaded into the output register.
// A submit or an unused code goes from execute to respond; a dispatch passes a
// pop state between them (registered FIFO memory read), and a completion a release
// state that releases its waiters, one FIFO push per cycle, lowest slot first.
// The next request can be taken in the cycle after the previous result is loaded.
// When the receiver stalls, the result holds in the output register and the
// block finishes the next request up to its result, then waits.
// Reset clears the job table, both FIFOs and the count, and sets accepting
// jobs to 1; no clearing pass is needed.
module dependency_counting_job_scheduler_top #(
    parameter int MAX_JOBS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               job_valid,
    output logic               job_stall,
    input  dcjs_pkg::job_req_t job,
    output logic               result_valid,
    input  logic               result_stall,
    output dcjs_pkg::job_rsp_t result
);

    dcjs_pkg::dp_cmd_t  cmd;
    dcjs_pkg::dp_stat_t st;

    dcjs_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_stall    (job_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .st           (st),
        .cmd          (cmd)
    );

    dcjs_datapath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .job       (job),
        .cmd       (cmd),
        .st        (st),
        .result    (result)
    );

endmodule

[tb/tb_dependency_counting_job_scheduler_top.sv]
// Testbench for the job scheduler: random and directed requests against a predictor.
`timescale 1ns / 100ps

module tb_dependency_counting_job_scheduler_top;

    // Operation code that the block must treat as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NUM_SLOTS = 32;
    localparam int SETTLE_CYCLES = 60;
    localparam int QUEUE_DEPTH = 2048;

    // Scheduler state as the predictor keeps it.
    typedef struct packed {
        logic                         accepting;
        logic [NUM_SLOTS-1:0]         active;
        logic [NUM_SLOTS-1:0]         high;
        logic [NUM_SLOTS-1:0][31:0]   waits;
        logic [NUM_SLOTS-1:0][4:0]    hi_ent;
        logic [4:0]                   hi_head;
        logic [5:0]                   hi_count;
        logic [NUM_SLOTS-1:0][4:0]    lo_ent;
        logic [4:0]                   lo_head;
        logic [5:0]                   lo_count;
        logic [5:0]                   outstanding;
    } sched_state_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_data = 1'b1;
    logic               job_valid = 1'b0;
    logic               job_stall;
    dcjs_pkg::job_req_t job = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    dcjs_pkg::job_rsp_t result;

    sched_state_t       live_state;
    sched_state_t       plan_state;
    dcjs_pkg::job_req_t pending_jobs [QUEUE_DEPTH];
    logic [10:0]        pend_head = '0;
    logic [10:0]        pend_tail = '0;
    dcjs_pkg::job_rsp_t expected_results [QUEUE_DEPTH];
    logic [10:0]        exp_head = '0;
    logic [10:0]        exp_tail = '0;
    logic               gaps_enabled = 1'b1;
    int                 mismatches = 0;
    int                 results_seen = 0;
    int                 status_seen[8];

    dependency_counting_job_scheduler_top #(.MAX_JOBS(NUM_SLOTS)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .job_valid    (job_valid),
        .job_stall    (job_stall),
        .job          (job),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    // Push a ready job into the FIFO of its priority; a full FIFO drops it.
    function automatic void enqueue_ready(inout sched_state_t s, input int slot);
        if (s.high[slot])
        begin
            if (s.hi_count < NUM_SLOTS)
            begin
                s.hi_ent[5'(s.hi_head + s.hi_count[4:0])] = 5'(slot);
                s.hi_count++;
            end
        end
        else if (s.lo_count < NUM_SLOTS)
        begin
            s.lo_ent[5'(s.lo_head + s.lo_count[4:0])] = 5'(slot);
            s.lo_count++;
        end
    endfunction

    // Apply one request to the scheduler state and return its result.
    function automatic dcjs_pkg::job_rsp_t schedule_step(inout sched_state_t s,
                                                         input dcjs_pkg::job_req_t r);
        dcjs_pkg::job_rsp_t rsp;
        int                 slot;
        logic [31:0]        live;
        rsp = '0;
        if (r.operation == dcjs_pkg::OP_SUBMIT)
        begin
            if (!s.accepting)
                rsp.status = dcjs_pkg::STAT_NOT_ACCEPTING;
            else if (&s.active)
                rsp.status = dcjs_pkg::STAT_TABLE_FULL;
            else
            begin
                slot = 0;
                while (s.active[slot])
                    slot++;
                // Only dependencies on live jobs are counted.
                live = r.dependency_mask & s.active;
                s.active[slot] = 1'b1;
                s.high[slot] = r.job_priority;
                s.waits[slot] = live;
                if (live == 0)
                    enqueue_ready(s, slot);
                s.outstanding++;
                rsp.result_slot = 5'(slot);
            end
        end
        else if (r.operation == dcjs_pkg::OP_DISPATCH)
        begin
            // High priority FIFO drains first.
            if (s.hi_count != 0)
            begin
                rsp.result_slot = s.hi_ent[s.hi_head];
                rsp.result_priority = 1'b1;
                s.hi_head++;
                s.hi_count--;
            end
            else if (s.lo_count != 0)
            begin
                rsp.result_slot = s.lo_ent[s.lo_head];
                s.lo_head++;
                s.lo_count--;
            end
            else
                rsp.status = dcjs_pkg::STAT_NOTHING_READY;
        end
        else if (r.operation == dcjs_pkg::OP_COMPLETE)
        begin
            if (!s.active[r.job_slot])
                rsp.status = dcjs_pkg::STAT_SLOT_INACTIVE;
            else
            begin
                s.active[r.job_slot] = 1'b0;
                s.waits[r.job_slot] = '0;
                // Released waiters are queued in ascending slot order.
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    if (s.active[k] && s.waits[k][r.job_slot])
                    begin
                        s.waits[k][r.job_slot] = 1'b0;
                        if (s.waits[k] == 0)
                            enqueue_ready(s, k);
                    end
                end
                if (s.outstanding > 0)
                    s.outstanding--;
                rsp.all_done = (s.outstanding == 0);
            end
        end
        rsp.jobs_outstanding = s.outstanding;
        return rsp;
    endfunction

    // Queue one request and advance the planning copy of the state.
    task automatic add_job(input logic [1:0] op, input logic prio, input logic [31:0] deps,
                           input logic [4:0] slot);
        dcjs_pkg::job_req_t r;
        dcjs_pkg::job_rsp_t unused_rsp;
        r.operation = op;
        r.job_priority = prio;
        r.dependency_mask = deps;
        r.job_slot = slot;
        unused_rsp = schedule_step(plan_state, r);
        pending_jobs[pend_tail] = r;
        pend_tail++;
    endtask

    // Random requests, mostly well formed against the planned job table.
    task automatic add_random_jobs(input int count, input int submit_pct);
        int          pick;
        logic [4:0]  slot;
        logic [31:0] deps;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            slot = 5'($urandom_range(0, NUM_SLOTS - 1));
            deps = $urandom();
            if (pick < submit_pct)
            begin
                // Usually depend on a few live jobs, sometimes on anything.
                if ($urandom_range(0, 3) != 0)
                    deps = deps & $urandom() & plan_state.active;
                add_job(dcjs_pkg::OP_SUBMIT, 1'($urandom()), deps, slot);
            end
            else if (pick < submit_pct + (100 - submit_pct) / 2)
                add_job(dcjs_pkg::OP_DISPATCH, 1'($urandom()), deps, slot);
            else if (pick < 97)
            begin
                if (plan_state.active != 0 && $urandom_range(0, 9) != 0)
                    while (!plan_state.active[slot])
                        slot = 5'($urandom_range(0, NUM_SLOTS - 1));
                add_job(dcjs_pkg::OP_COMPLETE, 1'($urandom()), deps, slot);
            end
            else
                add_job(OP_UNUSED, 1'($urandom()), deps, slot);
        end
    endtask

    // Wait until every request is taken and answered, then let the block settle.
    task automatic wait_idle();
        while (pend_head != pend_tail || job_valid || exp_head != exp_tail)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_accepting(input logic value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        live_state.accepting = value;
        cfg_write <= 1'b0;
        plan_state.accepting = value;
    endtask

    // Request driver: holds a stalled request, otherwise idles or sends the next one.
    always @(posedge clk)
    begin
        dcjs_pkg::job_rsp_t predicted;
        logic               next_valid;
        int                 gap_left;
        if (rst_n)
        begin
            next_valid = job_valid;
            if (job_valid && !job_stall)
            begin
                predicted = schedule_step(live_state, job);
                expected_results[exp_tail] = predicted;
                exp_tail++;
            end
            if (!(job_valid && job_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    next_valid = 1'b0;
                end
                else if (gaps_enabled && $urandom_range(0, 9) == 0)
                begin
                    gap_left = $urandom_range(1, 14) - 1;
                    next_valid = 1'b0;
                end
                else if (pend_head != pend_tail)
                begin
                    job <= pending_jobs[pend_head];
                    pend_head++;
                    next_valid = 1'b1;
                end
                else
                    next_valid = 1'b0;
            end
            job_valid <= next_valid;
        end
        else
            gap_left = 0;
    end

    // Result monitor with random stall bursts.
    always @(posedge clk)
    begin
        dcjs_pkg::job_rsp_t want;
        int                 stall_left;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                status_seen[result.status]++;
                if (exp_head == exp_tail)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result %p with nothing pending", result);
                end
                else
                begin
                    want = expected_results[exp_head];
                    exp_head++;
                    if (result.status !== want.status
                        || result.result_slot !== want.result_slot
                        || result.result_priority !== want.result_priority
                        || result.jobs_outstanding !== want.jobs_outstanding
                        || result.all_done !== want.all_done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result %0d: expected %p, got %p", results_seen, want,
                                     result);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (gaps_enabled && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
        else
            stall_left = 0;
    end

    // Stimulus phases and final report.
    initial
    begin
        live_state = '0;
        live_state.accepting = 1'b1;
        plan_state = live_state;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: priorities, extreme masks, release order, error cases.
        add_job(dcjs_pkg::OP_DISPATCH, 1'b0, 32'h0, 5'd0);
        add_job(dcjs_pkg::OP_COMPLETE, 1'b0, 32'h0, 5'd31);
        add_job(dcjs_pkg::OP_SUBMIT, 1'b0, 32'hFFFF_FFFF, 5'd0);
        add_job(dcjs_pkg::OP_SUBMIT, 1'b1, 32'h0, 5'd31);
        add_job(dcjs_pkg::OP_SUBMIT, 1'b1, 32'hFFFF_FFFF, 5'd0);
        add_job(dcjs_pkg::OP_SUBMIT, 1'b0, 32'h0000_0003, 5'd0);
        add_job(dcjs_pkg::OP_SUBMIT, 1'b1, 32'h0000_0001, 5'd0);
        add_job(dcjs_pkg::OP_SUBMIT, 1'b0, 32'hFFFF_FFF0, 5'd0);
        add_job(dcjs_pkg::OP_DISPATCH, 1'b0, 32'h0, 5'd0);
        add_job(dcjs_pkg::OP_COMPLETE, 1'b1, 32'hFFFF_FFFF, 5'd1);
        add_job(dcjs_pkg::OP_COMPLETE, 1'b0, 32'h0, 5'd0);
        add_job(dcjs_pkg::OP_DISPATCH, 1'b1, 32'h0, 5'd0);
        add_job(dcjs_pkg::OP_DISPATCH, 1'b0, 32'h0, 5'd0);
        add_job(dcjs_pkg::OP_DISPATCH, 1'b0, 32'h0, 5'd0);
        add_job(dcjs_pkg::OP_DISPATCH, 1'b0, 32'h0, 5'd0);
        add_job(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 5'd31);
        add_job(dcjs_pkg::OP_COMPLETE, 1'b0, 32'h0, 5'd1);
        add_job(dcjs_pkg::OP_COMPLETE, 1'b0, 32'h0, 5'd2);
        add_job(dcjs_pkg::OP_COMPLETE, 1'b0, 32'h0, 5'd3);
        add_job(dcjs_pkg::OP_COMPLETE, 1'b0, 32'h0, 5'd4);
        add_job(dcjs_pkg::OP_COMPLETE, 1'b0, 32'h0, 5'd4);
        wait_idle();

        // Submits rejected while not accepting.
        write_accepting(1'b0);
        add_random_jobs(40, 50);
        wait_idle();
        write_accepting(1'b1);
        add_random_jobs(600, 40);
        wait_idle();

        // Submit heavy traffic drives the table full.
        add_random_jobs(400, 70);
        wait_idle();
        write_accepting(1'b0);
        add_random_jobs(100, 30);
        wait_idle();
        write_accepting(1'b1);

        // Final stretch at full rate.
        gaps_enabled = 1'b0;
        add_random_jobs(500, 40);
        wait_idle();

        $display("Checked %0d results: %0d ok, %0d not accepting, %0d table full,",
                 results_seen, status_seen[dcjs_pkg::STAT_OK],
                 status_seen[dcjs_pkg::STAT_NOT_ACCEPTING],
                 status_seen[dcjs_pkg::STAT_TABLE_FULL]);
        $display("  %0d nothing ready, %0d inactive slot; %0d mismatches.",
                 status_seen[dcjs_pkg::STAT_NOTHING_READY],
                 status_seen[dcjs_pkg::STAT_SLOT_INACTIVE], mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

endmodule

[dependency_counting_job_scheduler_top.f]
+incdir+rtl/core
rtl/core/dcjs_pkg.sv
rtl/core/dcjs_datapath.sv
rtl/core/dcjs_controller.sv
rtl/core/dependency_counting_job_scheduler_top.sv
tb/tb_dependency_counting_job_scheduler_top.sv
